/* hdl/bdd_pkg.sv */
// ----------------------------------------------------------------------------
// bdd_pkg
// shared constants, register codes and control types for the balanced
// digit decomposition block
// ----------------------------------------------------------------------------
package bdd_pkg;

  // default parameter values
  localparam int COEFF_BITS_DEF = 60;
  localparam int MAX_DIGITS_DEF = 64;

  // fixed field widths
  localparam int DIGIT_IDX_W = 6;
  localparam int SDIGIT_W    = 9;
  localparam int BLOG_W      = 4;
  localparam int DCNT_W      = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int RAW_W       = 8;

  // base_log2 limits
  localparam logic [BLOG_W-1:0] BLOG_MIN = BLOG_W'(1);
  localparam logic [BLOG_W-1:0] BLOG_MAX = BLOG_W'(8);

  // register reset values
  localparam logic [63:0]       MODULUS_RST = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [BLOG_W-1:0] BLOG_RST    = BLOG_W'(1);
  localparam logic [DCNT_W-1:0] DCNT_RST    = DCNT_W'(62);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_BASE_LOG2   = 2'd1,
    CFG_DIGIT_COUNT = 2'd2
  } cfg_reg_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } bdd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
  } bdd_stat_t;

endpackage

/* hdl/bdd_stream_if.sv */
// ----------------------------------------------------------------------------
// bdd stream interfaces
// valid/ready channels for coefficients in and digits out
// ----------------------------------------------------------------------------
interface bdd_in_if #(
  parameter int COEFF_BITS = bdd_pkg::COEFF_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COEFF_BITS-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

interface bdd_out_if #(
  parameter int COEFF_BITS = bdd_pkg::COEFF_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [bdd_pkg::DIGIT_IDX_W-1:0]        digit_index;
  logic signed [bdd_pkg::SDIGIT_W-1:0]    signed_digit;
  logic [COEFF_BITS-1:0]                  digit_mod_q;
  logic                                   last_digit;
  logic                                   overflow;

  modport source (output valid, output digit_index, output signed_digit,
                  output digit_mod_q, output last_digit, output overflow,
                  input ready);
  modport sink   (input valid, input digit_index, input signed_digit,
                  input digit_mod_q, input last_digit, input overflow,
                  output ready);
endinterface

/* hdl/bdd_ctrl.sv */
// ----------------------------------------------------------------------------
// bdd_ctrl
// sequencer: takes a coefficient, then steps one digit per free output slot
// ----------------------------------------------------------------------------
module bdd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bdd_pkg::bdd_cmd_t   cmd,
  input  bdd_pkg::bdd_stat_t  stat
);

  bdd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      bdd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bdd_pkg::ST_RUN;
        end
      end
      bdd_pkg::ST_RUN: begin
        if (slot_free) begin
          cmd.step      = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.last) begin
            // next coefficient may start as the final digit goes out
            in_ready = 1'b1;
            if (in_valid) begin
              cmd.load = 1'b1;
            end else begin
              state_nxt = bdd_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = bdd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/bdd_datapath.sv */
// ----------------------------------------------------------------------------
// bdd_datapath
// config registers, remaining value, tie toggle, digit counter and the
// output register; one balanced digit per step
// ----------------------------------------------------------------------------
module bdd_datapath #(
  parameter int COEFF_BITS = bdd_pkg::COEFF_BITS_DEF,
  parameter int MAX_DIGITS = bdd_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bdd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEFF_BITS-1:0]               cfg_data,
  input  logic [COEFF_BITS-1:0]               coefficient,
  input  bdd_pkg::bdd_cmd_t                   cmd,
  output bdd_pkg::bdd_stat_t                  stat,
  output logic [bdd_pkg::DIGIT_IDX_W-1:0]     digit_index,
  output logic signed [bdd_pkg::SDIGIT_W-1:0] signed_digit,
  output logic [COEFF_BITS-1:0]               digit_mod_q,
  output logic                                last_digit,
  output logic                                overflow
);

  localparam int REM_W = COEFF_BITS + 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int SW    = bdd_pkg::SDIGIT_W;
  localparam int RW    = bdd_pkg::RAW_W;

  // configuration registers
  logic [COEFF_BITS-1:0]          modulus_r;
  logic [bdd_pkg::BLOG_W-1:0]     blog_r;
  logic [bdd_pkg::DCNT_W-1:0]     dcnt_r;

  // per-coefficient working state
  logic [REM_W-1:0]               rem_r, rem_nxt;
  logic                           tie_r, tie_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [bdd_pkg::BLOG_W-1:0]     b_r, b_load;
  logic [CNT_W-1:0]               n_r, n_load;

  // output register
  logic [bdd_pkg::DIGIT_IDX_W-1:0] idx_r;
  logic signed [SW-1:0]            sdig_r;
  logic [COEFF_BITS-1:0]           modq_r;
  logic                            last_r;
  logic                            ovf_r;

  logic [SW-1:0]  base;
  logic [RW-1:0]  raw_mask, half, raw;
  logic [SW-1:0]  mag;
  logic           tie, neg, last;
  logic [SW-1:0]  sdig;
  logic [COEFF_BITS-1:0] modq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= COEFF_BITS'(bdd_pkg::MODULUS_RST);
      blog_r    <= bdd_pkg::BLOG_RST;
      dcnt_r    <= bdd_pkg::DCNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdd_pkg::CFG_MODULUS:     modulus_r <= cfg_data;
        bdd_pkg::CFG_BASE_LOG2:   blog_r    <= bdd_pkg::BLOG_W'(cfg_data);
        bdd_pkg::CFG_DIGIT_COUNT: dcnt_r    <= bdd_pkg::DCNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // clamp base_log2 to 1..8 and digit count to 1..MAX_DIGITS at load
  always_comb begin
    if (blog_r < bdd_pkg::BLOG_MIN) begin
      b_load = bdd_pkg::BLOG_MIN;
    end else if (blog_r > bdd_pkg::BLOG_MAX) begin
      b_load = bdd_pkg::BLOG_MAX;
    end else begin
      b_load = blog_r;
    end
    if (dcnt_r == '0) begin
      n_load = CNT_W'(1);
    end else if (32'(dcnt_r) > 32'(MAX_DIGITS)) begin
      n_load = CNT_W'(MAX_DIGITS);
    end else begin
      n_load = CNT_W'(dcnt_r);
    end
  end

  // digit arithmetic
  always_comb begin
    base     = SW'(1) << b_r;
    raw_mask = RW'(base - SW'(1));
    half     = RW'(base >> 1);
    raw      = rem_r[RW-1:0] & raw_mask;
    tie      = (raw == half);
    neg      = (raw > half) || (tie && !tie_r);
    mag      = neg ? (base - SW'(raw)) : SW'(raw);
    sdig     = neg ? (SW'(0) - mag) : mag;
    modq     = neg ? (modulus_r - COEFF_BITS'(mag)) : COEFF_BITS'(mag);
    last     = (cnt_r == n_r - CNT_W'(1));
  end

  always_comb begin
    rem_nxt = rem_r;
    tie_nxt = tie_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      rem_nxt = REM_W'(coefficient);
      tie_nxt = 1'b0;
      cnt_nxt = '0;
    end else if (cmd.step) begin
      rem_nxt = (rem_r >> b_r) + REM_W'(neg);
      tie_nxt = tie_r ^ tie;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      tie_r <= 1'b0;
      cnt_r <= '0;
      b_r   <= bdd_pkg::BLOG_MIN;
      n_r   <= CNT_W'(1);
    end else begin
      rem_r <= rem_nxt;
      tie_r <= tie_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.load) begin
        b_r <= b_load;
        n_r <= n_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      idx_r  <= bdd_pkg::DIGIT_IDX_W'(cnt_r);
      sdig_r <= sdig;
      modq_r <= modq;
      last_r <= last;
      ovf_r  <= last && (((rem_r >> b_r) + REM_W'(neg)) != '0);
    end
  end

  assign stat.last    = last;
  assign digit_index  = idx_r;
  assign signed_digit = sdig_r;
  assign digit_mod_q  = modq_r;
  assign last_digit   = last_r;
  assign overflow     = ovf_r;

endmodule

/* hdl/balanced_digit_decompose.sv */
// ----------------------------------------------------------------------------
// balanced_digit_decompose
// splits each coefficient into balanced base-2^b digits, lsd first, each
// given as a signed digit and as its residue mod q
// ----------------------------------------------------------------------------
//
// channel   dir  payload                                            handshake
// in_ch     in   coefficient                                        valid/ready
// out_ch    out  digit_index, signed_digit, digit_mod_q,            valid/ready
//                last_digit, overflow
// cfg_*     in   cfg_index, cfg_data (modulus, base_log2, count)    cfg_we only
//
// one digit leaves per cycle while out_ch does not stall, and a coefficient
// gives digit_count digits (1..MAX_DIGITS), set by the single-step digit loop
// in the datapath, after a load when the sequencer picks it up from idle
// the next coefficient is taken in the cycle its predecessor's last digit
// is stepped, so items run back to back with no load step between them
// a stall on out_ch holds the output register and freezes the digit loop
// synchronous active-low reset clears the sequencer, output valid, working
// state and loads the configuration reset values
//
module balanced_digit_decompose #(
  parameter int COEFF_BITS = bdd_pkg::COEFF_BITS_DEF,
  parameter int MAX_DIGITS = bdd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [bdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_BITS-1:0]         cfg_data,
  // coefficient items in
  bdd_in_if.sink                        in_ch,
  // digit items out
  bdd_out_if.source                     out_ch
);

  // command and status between sequencer and datapath
  bdd_pkg::bdd_cmd_t  cmd;
  bdd_pkg::bdd_stat_t stat;

  // sequencer: owns the handshakes and the output valid flag
  bdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: registers, digit arithmetic and output payload
  bdd_datapath #(
    .COEFF_BITS (COEFF_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coefficient  (in_ch.coefficient),
    .cmd          (cmd),
    .stat         (stat),
    .digit_index  (out_ch.digit_index),
    .signed_digit (out_ch.signed_digit),
    .digit_mod_q  (out_ch.digit_mod_q),
    .last_digit   (out_ch.last_digit),
    .overflow     (out_ch.overflow)
  );

endmodule
